FILE: rtl/phre_pkg.sv
package phre_pkg;

   // Field widths of the channels
   localparam int DATA_W     = 32;
   localparam int ACT_W      = 2;
   localparam int IDX_W      = 2;
   localparam int CNT_S_W    = 3;
   localparam int CNT_P_W    = 2;
   localparam int CSR_ADDR_W = 2;
   localparam int CSR_DATA_W = 8;

   // Result vector sizes seen on the response channel
   localparam int OUT_STATES = 4;
   localparam int OUT_PORTS  = 2;

   // Arithmetic widths: J-R difference, exact product, wide accumulator
   localparam int DIFF_W = DATA_W + 1;
   localparam int PROD_W = 2 * DATA_W + 1;
   localparam int WIDE_W = PROD_W + 3;

   // Transaction action codes
   localparam logic [ACT_W-1:0] ACT_WRITE_J = 2'd0;
   localparam logic [ACT_W-1:0] ACT_WRITE_R = 2'd1;
   localparam logic [ACT_W-1:0] ACT_WRITE_G = 2'd2;
   localparam logic [ACT_W-1:0] ACT_EVAL    = 2'd3;

   // Control register indexes and reset values
   localparam logic [CSR_ADDR_W-1:0] CSR_STATE_COUNT = 2'd0;
   localparam logic [CSR_ADDR_W-1:0] CSR_PORT_COUNT  = 2'd1;
   localparam logic [CNT_S_W-1:0]    STATE_COUNT_RESET = 3'd2;
   localparam logic [CNT_P_W-1:0]    PORT_COUNT_RESET  = 2'd1;

   typedef logic signed [DATA_W-1:0] q_type;
   typedef logic signed [DIFF_W-1:0] diff_type;
   typedef logic signed [PROD_W-1:0] prod_type;
   typedef logic signed [WIDE_W-1:0] wide_type;

   localparam q_type Q_MAX = 32'sh7FFF_FFFF;
   localparam q_type Q_MIN = 32'sh8000_0000;

   typedef struct packed {
      q_type value;
      logic  ov;
   } sat_type;

   // Load strobes for pipeline stages 2 through 5
   typedef struct packed {
      logic s2;
      logic s3;
      logic s4;
      logic s5;
   } stage_en_type;

   // Clamp a wide sum to signed 32 bits and flag the clamp
   function automatic sat_type sat_q(input wide_type v);
      sat_type s;
      if (v > WIDE_W'(Q_MAX)) begin
         s.value = Q_MAX;
         s.ov    = 1'b1;
      end else if (v < WIDE_W'(Q_MIN)) begin
         s.value = Q_MIN;
         s.ov    = 1'b1;
      end else begin
         s.value = v[DATA_W-1:0];
         s.ov    = 1'b0;
      end
      return s;
   endfunction

endpackage

FILE: rtl/phre_req_if.sv
interface phre_req_if;
   import phre_pkg::*;

   logic                valid;
   logic                ready;
   logic [ACT_W-1:0]    action;
   logic [IDX_W-1:0]    row;
   logic [IDX_W-1:0]    col;
   logic signed [DATA_W-1:0] coef;
   logic signed [DATA_W-1:0] grad0;
   logic signed [DATA_W-1:0] grad1;
   logic signed [DATA_W-1:0] grad2;
   logic signed [DATA_W-1:0] grad3;
   logic signed [DATA_W-1:0] drive0;
   logic signed [DATA_W-1:0] drive1;
   logic                has_drive;

   modport source (
      output valid, action, row, col, coef, grad0, grad1, grad2, grad3,
             drive0, drive1, has_drive,
      input  ready
   );
   modport sink (
      input  valid, action, row, col, coef, grad0, grad1, grad2, grad3,
             drive0, drive1, has_drive,
      output ready
   );
endinterface

FILE: rtl/phre_rsp_if.sv
interface phre_rsp_if;
   import phre_pkg::*;

   logic                     valid;
   logic                     ready;
   logic signed [DATA_W-1:0] rate0;
   logic signed [DATA_W-1:0] rate1;
   logic signed [DATA_W-1:0] rate2;
   logic signed [DATA_W-1:0] rate3;
   logic signed [DATA_W-1:0] port0;
   logic signed [DATA_W-1:0] port1;
   logic signed [DATA_W-1:0] power;
   logic                     overflow;

   modport source (
      output valid, rate0, rate1, rate2, rate3, port0, port1, power, overflow,
      input  ready
   );
   modport sink (
      input  valid, rate0, rate1, rate2, rate3, port0, port1, power, overflow,
      output ready
   );
endinterface

FILE: rtl/phre_csr_if.sv
interface phre_csr_if;
   import phre_pkg::*;

   logic                  valid;
   logic                  ready;
   logic [CSR_ADDR_W-1:0] index;
   logic [CSR_DATA_W-1:0] data;

   modport source (output valid, index, data, input ready);
   modport sink   (input valid, index, data, output ready);
endinterface

FILE: rtl/phre_row_lane.sv
module phre_row_lane #(
   parameter int NS        = 4,
   parameter int NP        = 2,
   parameter int FRAC_BITS = 16
) (
   input  logic                   clock,
   input  phre_pkg::stage_en_type en,
   input  logic                   row_on,
   input  phre_pkg::diff_type     d_row [NS],
   input  phre_pkg::q_type        r_row [NS],
   input  phre_pkg::q_type        g_row [NP],
   input  phre_pkg::q_type        grad [NS],
   input  phre_pkg::q_type        drive [NP],
   input  phre_pkg::q_type        grad_self,
   output phre_pkg::q_type        rate,
   output phre_pkg::wide_type     diss,
   output logic                   ov
);
   import phre_pkg::*;

   localparam int SH_W = PROD_W - FRAC_BITS;
   typedef logic signed [SH_W-1:0] sh_type;

   sh_type   rp_in [NS+NP];
   sh_type   rp_ff [NS+NP];
   sh_type   dp_in [NS];
   sh_type   dp_ff [NS];
   q_type    gs2_ff;
   wide_type rate_sum;
   wide_type rsat_sum;
   sat_type  rate_sat;
   sat_type  rsat_sat;
   q_type    rate3_ff;
   q_type    rsat3_ff;
   q_type    gs3_ff;
   logic     ov3_ff;
   sh_type   diss_in;
   sh_type   diss4_ff;
   q_type    rate4_ff;
   logic     ov4_ff;

   // Stage 2: (J-R), g and R products for this row, floored by the fraction shift
   always_comb begin
      for (int j = 0; j < NS; j++) begin
         rp_in[j] = row_on ?
            SH_W'((PROD_W'(d_row[j]) * PROD_W'(grad[j])) >>> FRAC_BITS) : '0;
         dp_in[j] = row_on ?
            SH_W'((PROD_W'(r_row[j]) * PROD_W'(grad[j])) >>> FRAC_BITS) : '0;
      end
      for (int k = 0; k < NP; k++) begin
         rp_in[NS+k] = row_on ?
            SH_W'((PROD_W'(g_row[k]) * PROD_W'(drive[k])) >>> FRAC_BITS) : '0;
      end
   end

   always_ff @(posedge clock) begin
      if (en.s2) begin
         rp_ff  <= rp_in;
         dp_ff  <= dp_in;
         gs2_ff <= grad_self;
      end
   end

   // Stage 3: row sums, both saturated
   always_comb begin
      rate_sum = '0;
      rsat_sum = '0;
      for (int k = 0; k < NS + NP; k++) begin
         rate_sum = rate_sum + WIDE_W'(rp_ff[k]);
      end
      for (int j = 0; j < NS; j++) begin
         rsat_sum = rsat_sum + WIDE_W'(dp_ff[j]);
      end
      rate_sat = sat_q(rate_sum);
      rsat_sat = sat_q(rsat_sum);
   end

   always_ff @(posedge clock) begin
      if (en.s3) begin
         rate3_ff <= rate_sat.value;
         rsat3_ff <= rsat_sat.value;
         ov3_ff   <= rate_sat.ov | rsat_sat.ov;
         gs3_ff   <= gs2_ff;
      end
   end

   // Stage 4: dissipation term grad_i * (R*grad)_i
   assign diss_in = SH_W'((PROD_W'(gs3_ff) * PROD_W'(rsat3_ff)) >>> FRAC_BITS);

   always_ff @(posedge clock) begin
      if (en.s4) begin
         diss4_ff <= diss_in;
         rate4_ff <= rate3_ff;
         ov4_ff   <= ov3_ff;
      end
   end

   assign rate = rate4_ff;
   assign diss = WIDE_W'(diss4_ff);
   assign ov   = ov4_ff;

endmodule

FILE: rtl/phre_port_lane.sv
module phre_port_lane #(
   parameter int NS        = 4,
   parameter int FRAC_BITS = 16
) (
   input  logic                   clock,
   input  phre_pkg::stage_en_type en,
   input  logic                   port_on,
   input  phre_pkg::q_type        g_col [NS],
   input  phre_pkg::q_type        grad [NS],
   input  phre_pkg::q_type        drive_self,
   output phre_pkg::q_type        port,
   output phre_pkg::wide_type     sup,
   output logic                   ov
);
   import phre_pkg::*;

   localparam int SH_W = PROD_W - FRAC_BITS;
   typedef logic signed [SH_W-1:0] sh_type;

   sh_type   pp_in [NS];
   sh_type   pp_ff [NS];
   q_type    dr2_ff;
   wide_type port_sum;
   sat_type  port_sat;
   q_type    port3_ff;
   q_type    dr3_ff;
   logic     ov3_ff;
   sh_type   sup_in;
   sh_type   sup4_ff;
   q_type    port4_ff;
   logic     ov4_ff;

   // Stage 2: g column times gradient
   always_comb begin
      for (int j = 0; j < NS; j++) begin
         pp_in[j] = port_on ?
            SH_W'((PROD_W'(g_col[j]) * PROD_W'(grad[j])) >>> FRAC_BITS) : '0;
      end
   end

   always_ff @(posedge clock) begin
      if (en.s2) begin
         pp_ff  <= pp_in;
         dr2_ff <= drive_self;
      end
   end

   // Stage 3: port output, saturated
   always_comb begin
      port_sum = '0;
      for (int j = 0; j < NS; j++) begin
         port_sum = port_sum + WIDE_W'(pp_ff[j]);
      end
      port_sat = sat_q(port_sum);
   end

   always_ff @(posedge clock) begin
      if (en.s3) begin
         port3_ff <= port_sat.value;
         ov3_ff   <= port_sat.ov;
         dr3_ff   <= dr2_ff;
      end
   end

   // Stage 4: supplied power of this port
   assign sup_in = SH_W'((PROD_W'(port3_ff) * PROD_W'(dr3_ff)) >>> FRAC_BITS);

   always_ff @(posedge clock) begin
      if (en.s4) begin
         sup4_ff  <= sup_in;
         port4_ff <= port3_ff;
         ov4_ff   <= ov3_ff;
      end
   end

   assign port = port4_ff;
   assign sup  = WIDE_W'(sup4_ff);
   assign ov   = ov4_ff;

endmodule

FILE: rtl/phre_merge.sv
module phre_merge #(
   parameter int NS = 4,
   parameter int NP = 2
) (
   input  logic                   clock,
   input  phre_pkg::stage_en_type en,
   input  phre_pkg::q_type        rate [NS],
   input  phre_pkg::wide_type     diss [NS],
   input  logic [NS-1:0]          row_ov,
   input  phre_pkg::q_type        port [NP],
   input  phre_pkg::wide_type     sup [NP],
   input  logic [NP-1:0]          port_ov,
   output phre_pkg::q_type        rate_out [phre_pkg::OUT_STATES],
   output phre_pkg::q_type        port_out [phre_pkg::OUT_PORTS],
   output phre_pkg::q_type        power,
   output logic                   overflow
);
   import phre_pkg::*;

   wide_type bal;
   sat_type  bal_sat;
   logic     ov_any;
   q_type    rate5_ff [OUT_STATES];
   q_type    port5_ff [OUT_PORTS];
   q_type    power5_ff;
   logic     ov5_ff;

   // Power balance: supplied minus dissipated, then one clamp
   always_comb begin
      bal = '0;
      for (int k = 0; k < NP; k++) begin
         bal = bal + sup[k];
      end
      for (int i = 0; i < NS; i++) begin
         bal = bal - diss[i];
      end
      bal_sat = sat_q(bal);
      ov_any  = bal_sat.ov | (|row_ov) | (|port_ov);
   end

   always_ff @(posedge clock) begin
      if (en.s5) begin
         power5_ff <= bal_sat.value;
         ov5_ff    <= ov_any;
      end
   end

   // Result register; lanes that are not built read as zero
   for (genvar i = 0; i < OUT_STATES; i++) begin : g_rate
      if (i < NS) begin : g_used
         always_ff @(posedge clock) begin
            if (en.s5) begin
               rate5_ff[i] <= rate[i];
            end
         end
      end else begin : g_zero
         always_ff @(posedge clock) begin
            if (en.s5) begin
               rate5_ff[i] <= '0;
            end
         end
      end
      assign rate_out[i] = rate5_ff[i];
   end

   for (genvar k = 0; k < OUT_PORTS; k++) begin : g_port
      if (k < NP) begin : g_used
         always_ff @(posedge clock) begin
            if (en.s5) begin
               port5_ff[k] <= port[k];
            end
         end
      end else begin : g_zero
         always_ff @(posedge clock) begin
            if (en.s5) begin
               port5_ff[k] <= '0;
            end
         end
      end
      assign port_out[k] = port5_ff[k];
   end

   assign power    = power5_ff;
   assign overflow = ov5_ff;

endmodule

FILE: rtl/port_hamiltonian_rate_eval.sv
// Port-Hamiltonian rate evaluator, signed fixed point with FRAC_BITS fraction bits.
// req_ch carries one transaction per item: a write of one J, R or g entry, or an
// evaluate with the energy gradient and optional port drives. Writes give no
// response and take effect for every later transaction. Each evaluate gives one
// rsp_ch transaction: state rates (J-R)*grad + g*u, port outputs g^T*grad, the
// power balance y^T*u - grad^T*R*grad, and a saturation flag.
// csr_ch sets state_count (index 0) and port_count (index 1); it is always ready.
// csr_ch must be written only while the block is idle; this is not enforced.
// Throughput: one transaction per cycle on req_ch, writes and evaluates alike,
// whenever req_ch.ready is high. An accepted evaluate passes through the
// five-stage lane pipeline (input capture, products, row sums, second product,
// power balance into the result register) before its result is presented.
// One row lane per state and one lane per port run side by side.
// Reset clears the matrices, empties the pipeline and sets the counts to 2 and 1.
// When rsp_ch stalls, the pipeline holds its contents and bubbles are squeezed
// out; req_ch.ready drops only once all five stages are occupied.
module port_hamiltonian_rate_eval #(
   parameter int MAX_STATES = 4,
   parameter int MAX_PORTS  = 2,
   parameter int FRAC_BITS  = 16
) (
   input  logic        clock,
   input  logic        reset,
   phre_req_if.sink    req_ch,
   phre_rsp_if.source  rsp_ch,
   phre_csr_if.sink    csr_ch
);
   import phre_pkg::*;

   localparam int NS = (MAX_STATES < OUT_STATES) ? MAX_STATES : OUT_STATES;
   localparam int NP = (MAX_PORTS < OUT_PORTS) ? MAX_PORTS : OUT_PORTS;

   logic [CNT_S_W-1:0] state_count_ff;
   logic [CNT_P_W-1:0] port_count_ff;

   diff_type d_ff [NS][NS];
   q_type    j_ff [NS][NS];
   q_type    r_ff [NS][NS];
   q_type    g_ff [NS][NP];
   q_type    g_col [NP][NS];

   logic     wr_j;
   logic     wr_r;
   logic     wr_g;
   logic     eval_acc;

   logic [5:1]   v_ff;
   logic [5:1]   stage_room;
   stage_en_type en;

   q_type    grad_all [OUT_STATES];
   q_type    drive_all [OUT_PORTS];
   q_type    grad1_ff [NS];
   q_type    drive1_ff [NP];
   logic [NS-1:0] row_on1_ff;
   logic [NP-1:0] port_on1_ff;

   q_type    lane_rate [NS];
   wide_type lane_diss [NS];
   logic [NS-1:0] row_ov;
   q_type    lane_port [NP];
   wide_type lane_sup [NP];
   logic [NP-1:0] port_ov;

   q_type    rate_out [OUT_STATES];
   q_type    port_out [OUT_PORTS];
   q_type    power;
   logic     overflow;

   // Control registers
   assign csr_ch.ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_count_ff <= STATE_COUNT_RESET;
         port_count_ff  <= PORT_COUNT_RESET;
      end else if (csr_ch.valid) begin
         unique case (csr_ch.index)
            CSR_STATE_COUNT: state_count_ff <= csr_ch.data[CNT_S_W-1:0];
            CSR_PORT_COUNT:  port_count_ff  <= csr_ch.data[CNT_P_W-1:0];
            default: ;
         endcase
      end
   end

   // Pipeline flow control: a stage takes new data when empty or when it drains
   always_comb begin
      stage_room[5] = !v_ff[5] || rsp_ch.ready;
      for (int k = 4; k >= 1; k--) begin
         stage_room[k] = !v_ff[k] || stage_room[k+1];
      end
   end

   assign req_ch.ready = stage_room[1];
   assign wr_j     = req_ch.valid && stage_room[1] && (req_ch.action == ACT_WRITE_J);
   assign wr_r     = req_ch.valid && stage_room[1] && (req_ch.action == ACT_WRITE_R);
   assign wr_g     = req_ch.valid && stage_room[1] && (req_ch.action == ACT_WRITE_G);
   assign eval_acc = req_ch.valid && stage_room[1] && (req_ch.action == ACT_EVAL);

   assign en.s2 = stage_room[2] && v_ff[1];
   assign en.s3 = stage_room[3] && v_ff[2];
   assign en.s4 = stage_room[4] && v_ff[3];
   assign en.s5 = stage_room[5] && v_ff[4];

   always_ff @(posedge clock) begin
      if (reset) begin
         v_ff <= '0;
      end else begin
         if (stage_room[1]) begin
            v_ff[1] <= eval_acc;
         end
         for (int k = 2; k <= 5; k++) begin
            if (stage_room[k]) begin
               v_ff[k] <= v_ff[k-1];
            end
         end
      end
   end

   // Matrix store; D = J - R follows J and R in the next cycle, which is enough
   // since an evaluate reads it no earlier than the cycle after its acceptance
   always_ff @(posedge clock) begin
      if (reset) begin
         for (int r = 0; r < NS; r++) begin
            for (int c = 0; c < NS; c++) begin
               j_ff[r][c] <= '0;
               r_ff[r][c] <= '0;
               d_ff[r][c] <= '0;
            end
            for (int c = 0; c < NP; c++) begin
               g_ff[r][c] <= '0;
            end
         end
      end else begin
         for (int r = 0; r < NS; r++) begin
            for (int c = 0; c < NS; c++) begin
               if (wr_j && req_ch.row == IDX_W'(r) && req_ch.col == IDX_W'(c)) begin
                  j_ff[r][c] <= req_ch.coef;
               end
               if (wr_r && req_ch.row == IDX_W'(r) && req_ch.col == IDX_W'(c)) begin
                  r_ff[r][c] <= req_ch.coef;
               end
               d_ff[r][c] <= DIFF_W'(j_ff[r][c]) - DIFF_W'(r_ff[r][c]);
            end
            for (int c = 0; c < NP; c++) begin
               if (wr_g && req_ch.row == IDX_W'(r) && req_ch.col == IDX_W'(c)) begin
                  g_ff[r][c] <= req_ch.coef;
               end
            end
         end
      end
   end

   always_comb begin
      for (int k = 0; k < NP; k++) begin
         for (int j = 0; j < NS; j++) begin
            g_col[k][j] = g_ff[j][k];
         end
      end
   end

   // Stage 1: capture, zeroing unused states and drives, and drives if has_drive is low
   assign grad_all[0]  = req_ch.grad0;
   assign grad_all[1]  = req_ch.grad1;
   assign grad_all[2]  = req_ch.grad2;
   assign grad_all[3]  = req_ch.grad3;
   assign drive_all[0] = req_ch.drive0;
   assign drive_all[1] = req_ch.drive1;

   always_ff @(posedge clock) begin
      if (eval_acc) begin
         for (int j = 0; j < NS; j++) begin
            row_on1_ff[j] <= state_count_ff > CNT_S_W'(j);
            grad1_ff[j]   <= (state_count_ff > CNT_S_W'(j)) ? grad_all[j] : '0;
         end
         for (int k = 0; k < NP; k++) begin
            port_on1_ff[k] <= port_count_ff > CNT_P_W'(k);
            drive1_ff[k]   <= (req_ch.has_drive && port_count_ff > CNT_P_W'(k)) ?
                              drive_all[k] : '0;
         end
      end
   end

   // Lanes
   for (genvar i = 0; i < NS; i++) begin : g_row
      phre_row_lane #(
         .NS        (NS),
         .NP        (NP),
         .FRAC_BITS (FRAC_BITS)
      ) u_row_lane (
         .clock     (clock),
         .en        (en),
         .row_on    (row_on1_ff[i]),
         .d_row     (d_ff[i]),
         .r_row     (r_ff[i]),
         .g_row     (g_ff[i]),
         .grad      (grad1_ff),
         .drive     (drive1_ff),
         .grad_self (grad1_ff[i]),
         .rate      (lane_rate[i]),
         .diss      (lane_diss[i]),
         .ov        (row_ov[i])
      );
   end

   for (genvar k = 0; k < NP; k++) begin : g_port
      phre_port_lane #(
         .NS        (NS),
         .FRAC_BITS (FRAC_BITS)
      ) u_port_lane (
         .clock      (clock),
         .en         (en),
         .port_on    (port_on1_ff[k]),
         .g_col      (g_col[k]),
         .grad       (grad1_ff),
         .drive_self (drive1_ff[k]),
         .port       (lane_port[k]),
         .sup        (lane_sup[k]),
         .ov         (port_ov[k])
      );
   end

   // Merge and result register
   phre_merge #(
      .NS (NS),
      .NP (NP)
   ) u_merge (
      .clock    (clock),
      .en       (en),
      .rate     (lane_rate),
      .diss     (lane_diss),
      .row_ov   (row_ov),
      .port     (lane_port),
      .sup      (lane_sup),
      .port_ov  (port_ov),
      .rate_out (rate_out),
      .port_out (port_out),
      .power    (power),
      .overflow (overflow)
   );

   assign rsp_ch.valid    = v_ff[5];
   assign rsp_ch.rate0    = rate_out[0];
   assign rsp_ch.rate1    = rate_out[1];
   assign rsp_ch.rate2    = rate_out[2];
   assign rsp_ch.rate3    = rate_out[3];
   assign rsp_ch.port0    = port_out[0];
   assign rsp_ch.port1    = port_out[1];
   assign rsp_ch.power    = power;
   assign rsp_ch.overflow = overflow;

endmodule
